[design/sle_pkg.sv]
// Shared constants, codes and control types for the sorted list engine.
// Used by sle_ctrl, sle_dpath and sorted_list_engine_top; no dependencies.
package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic capture;
    logic select;
    logic commit;
  } sle_cmd_t;

endpackage

[design/sle_ctrl.sv]
// Request sequencer for the sorted list engine: handshakes and step commands.
// Depends on sle_pkg for the command struct.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output sle_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SELECT = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_commit;

  assign can_commit = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        if (can_commit) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/sle_dpath.sv]
// Datapath of the sorted list engine: the row of entry cells, the entry count,
// the registered position-select tree and the result register. Uses sle_pkg.
module sle_dpath
  import sle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  sle_cmd_t               cmd,
  input  logic [1:0]             in_user,
  input  logic [IN_TDATA_W-1:0]  in_data,
  output logic [1:0]             out_user,
  output logic [OUT_TDATA_W-1:0] out_data
);

  logic [1:0]       req_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [VAL_W-1:0] entry_r   [CAPACITY];
  logic [VAL_W-1:0] entry_nxt [CAPACITY];
  logic [VAL_W-1:0] ent_prev  [CAPACITY];
  logic [VAL_W-1:0] ent_next  [CAPACITY];
  logic [VAL_W-1:0] grp_r     [NGRP];
  logic [VAL_W-1:0] grp_nxt   [NGRP];
  logic [CAPACITY-1:0] le, le_prev, hit;
  logic [IDX_W-1:0] idx;
  logic             pos_ok;
  logic             full;
  logic [VAL_W-1:0] sel;
  logic [1:0]       status_nxt, status_r;
  logic [VAL_W-1:0] data_nxt, data_r;
  logic [CNT_W-1:0] ocount_r;

  assign full   = (32'(count_r) >= CAPACITY);
  assign pos_ok = (pos_r != '0) && (32'(pos_r) <= 32'(count_r));
  assign idx    = IDX_W'(pos_r - POS_W'(1));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i]  = (32'(i) < 32'(count_r)) && ($signed(entry_r[i]) <= $signed(val_r));
      hit[i] = pos_ok && (idx == IDX_W'(i));
      if (i == 0) begin
        ent_prev[i] = val_r;
      end else begin
        ent_prev[i] = entry_r[i-1];
      end
      if (i == CAPACITY - 1) begin
        ent_next[i] = entry_r[i];
      end else begin
        ent_next[i] = entry_r[i+1];
      end
    end
  end

  assign le_prev = {le[CAPACITY-2:0], 1'b1};

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          if (hit[g*GRP+k]) begin
            grp_nxt[g] = grp_nxt[g] | entry_r[g*GRP+k];
          end
        end
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int g = 0; g < NGRP; g++) begin
      sel = sel | grp_r[g];
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    data_nxt   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      entry_nxt[i] = entry_r[i];
    end
    case (req_r)
      REQ_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (!le[i]) begin
              entry_nxt[i] = le_prev[i] ? val_r : ent_prev[i];
            end
          end
        end
      end
      REQ_DELETE, REQ_READ: begin
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          data_nxt = sel;
          if (req_r == REQ_DELETE) begin
            count_nxt = count_r - CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (IDX_W'(i) >= idx) begin
                entry_nxt[i] = ent_next[i];
              end
            end
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_user;
      val_r <= in_data[VAL_W-1:0];
      pos_r <= in_data[VAL_W+POS_W-1:VAL_W];
    end
    if (cmd.select) begin
      grp_r <= grp_nxt;
    end
    if (cmd.commit) begin
      entry_r  <= entry_nxt;
      status_r <= status_nxt;
      data_r   <= data_nxt;
      ocount_r <= count_nxt;
    end
  end

  assign out_user = status_r;
  assign out_data = {{(OUT_TDATA_W - VAL_W - CNT_W){1'b0}}, ocount_r, data_r};

endmodule

[design/sorted_list_engine_top.sv]
// Top level of the sorted list engine: sequencer plus datapath.
// Depends on sle_pkg, sle_ctrl and sle_dpath.
//
// The block keeps up to 64 signed 32-bit values in ascending order, equal
// values in arrival order. A request arrives on the in_ stream: in_tuser is
// the request kind (insert, delete at position, read at position), in_tdata
// carries the value and the 1-based position. Each request yields exactly one
// result word on the out_ stream: out_tuser is the status (ok, bad position,
// full), out_tdata holds the value read or removed and the entry count.
// A request passes through a capture step, a select step that registers the
// eight-way groups of the position select, and a commit step that updates the
// row of entry cells and loads the result register. The engine takes no new
// request until the previous one has been committed.
// A new request may be accepted while the previous result still waits in the
// output register. If the receiver stalls, the engine holds the next result
// in its commit step until the output register frees up.
// Reset clears the entry count and the output valid and returns the sequencer
// to idle; no entry is readable until it has been inserted.
module sorted_list_engine_top
  import sle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0], position[38:32], zero pad
  input  logic [1:0]             in_tuser,   // req_type[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data_out[31:0], entry_count[38:32], zero pad
  output logic [1:0]             out_tuser   // status[1:0]
);

  sle_cmd_t cmd;

  sle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sle_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_user  (in_tuser),
    .in_data  (in_tdata),
    .out_user (out_tuser),
    .out_data (out_tdata)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("engine accepted a request while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[38:32]) <= CAPACITY))
    else $error("entry count exceeds capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> (32'(out_tdata[38:32]) == CAPACITY))
    else $error("full status with store not full");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[31:0] == '0))
    else $error("error result carries nonzero data");
`endif

endmodule

[tb/sorted_list_engine_top_tb.sv]
// Self-checking testbench for sorted_list_engine_top: directed and random
// insert, delete and read requests, checked against an ordered-list predictor.
// Depends on sle_pkg and sorted_list_engine_top.
module sorted_list_engine_top_tb;
  import sle_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int unsigned REQUEST_BUDGET = 1600;
  localparam int PH_FILL  = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_MIX   = 2;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] data;
    logic [CNT_W-1:0] count;
  } list_answer_t;

  class list_scoreboard;
    logic [VAL_W-1:0] entries [CAPACITY];
    int unsigned      fill;
    list_answer_t     answers_q [$];
    int unsigned      errors;

    function void note_request(logic [1:0] kind, logic [VAL_W-1:0] value,
                               logic [POS_W-1:0] position);
      list_answer_t ans;
      int unsigned  slot;
      ans.status = ST_OK;
      ans.data   = '0;
      if (kind == REQ_INSERT) begin
        if (fill >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < fill && $signed(entries[slot]) <= $signed(value)) slot++;
          for (int i = fill; i > slot; i--) entries[i] = entries[i-1];
          entries[slot] = value;
          fill++;
        end
      end else if (kind == REQ_DELETE || kind == REQ_READ) begin
        if (position == 0 || position > fill) begin
          ans.status = ST_BADPOS;
        end else begin
          ans.data = entries[position-1];
          if (kind == REQ_DELETE) begin
            for (int i = position - 1; i + 1 < fill; i++) entries[i] = entries[i+1];
            fill--;
          end
        end
      end
      ans.count = fill[CNT_W-1:0];
      answers_q.push_back(ans);
    endfunction

    function void check_result(logic [1:0] status, logic [VAL_W-1:0] data,
                               logic [CNT_W-1:0] count);
      list_answer_t want;
      if (answers_q.size() == 0) begin
        $display("%0t: unexpected result word status=%0d data=%h count=%0d",
                 $time, status, data, count);
        errors++;
        return;
      end
      want = answers_q.pop_front();
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
      if (data !== want.data) begin
        $display("%0t: data expected %h actual %h", $time, want.data, data);
        errors++;
      end
      if (count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return answers_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  list_scoreboard sb;
  bit             sender_no_idle;
  bit             receiver_no_stall;
  int unsigned    requests_sent;

  sorted_list_engine_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with the word still presented, so back-to-back words need no toggle.
  task automatic send_request(input logic [1:0] kind, input logic [VAL_W-1:0] value,
                              input logic [POS_W-1:0] position);
    int unsigned gap;
    gap = sender_no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, position, value};
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, value, position);
    if (kind != REQ_NONE) requests_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    if (r <= 2) return 32'($signed($urandom_range(0, 6)) - 3);
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_position(int unsigned count);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (count > 0 && r < 85) return POS_W'($urandom_range(1, count));
    if (r < 90) return '0;
    if (r < 95) return POS_W'(count + 1);
    return POS_W'($urandom_range(0, 127));
  endfunction

  // Result side: random stall before each word, with long stretches of none.
  initial begin
    int unsigned stall;
    receiver_no_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 63) == 0) receiver_no_stall = !receiver_no_stall;
      stall = receiver_no_stall ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata[VAL_W-1:0], out_tdata[VAL_W+CNT_W-1:VAL_W]);
    end
  end

  initial begin
    #1000000;
    $display("[sorted_list_engine_top] ERROR");
    $finish;
  end

  initial begin
    int unsigned phase_len;
    int unsigned insert_weight;
    int unsigned r;
    sb = new;
    requests_sent  = 0;
    sender_no_idle = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_INSERT;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty store, position zero and the unused request kind.
    send_request(REQ_READ, 32'h0, 7'd1);
    send_request(REQ_DELETE, 32'hffff_ffff, 7'd0);
    send_request(REQ_NONE, 32'hffff_ffff, 7'h7f);
    // Signed extremes, zero, neighbors and equal values.
    send_request(REQ_INSERT, 32'h7fff_ffff, 7'h7f);
    send_request(REQ_INSERT, 32'h8000_0000, 7'd0);
    send_request(REQ_INSERT, 32'h0000_0000, 7'd3);
    send_request(REQ_INSERT, 32'hffff_ffff, 7'd0);
    send_request(REQ_INSERT, 32'h0000_0001, 7'd0);
    send_request(REQ_INSERT, 32'h0000_0005, 7'd0);
    send_request(REQ_INSERT, 32'h0000_0005, 7'd0);
    send_request(REQ_READ, 32'h0, 7'd1);
    send_request(REQ_READ, 32'h0, 7'd7);
    send_request(REQ_READ, 32'h0, 7'd8);
    send_request(REQ_READ, 32'h0, 7'h7f);
    send_request(REQ_READ, 32'h0, 7'd0);
    send_request(REQ_NONE, 32'h1234_5678, 7'd2);
    send_request(REQ_DELETE, 32'h0, 7'd4);
    send_request(REQ_DELETE, 32'h0, 7'd6);
    send_request(REQ_DELETE, 32'h0, 7'd1);
    send_request(REQ_DELETE, 32'h0, 7'd5);
    send_request(REQ_DELETE, 32'h0, 7'h40);
    send_request(REQ_READ, 32'h0, 7'd2);
    drain_results();

    while (requests_sent < REQUEST_BUDGET) begin
      sender_no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(PH_FILL, PH_MIX))
        PH_FILL: begin
          while (sb.fill < CAPACITY) begin
            send_request(REQ_INSERT, pick_value(), POS_W'($urandom()));
          end
          repeat ($urandom_range(1, 4)) begin
            send_request(REQ_INSERT, pick_value(), POS_W'($urandom()));
          end
          send_request(REQ_READ, $urandom(), 7'(CAPACITY));
          send_request(REQ_READ, $urandom(), 7'(CAPACITY + 1));
        end
        PH_DRAIN: begin
          while (sb.fill > 0) begin
            send_request($urandom_range(0, 3) == 0 ? REQ_READ : REQ_DELETE,
                         $urandom(), pick_position(sb.fill));
          end
          send_request(REQ_DELETE, $urandom(), pick_position(0));
          send_request(REQ_READ, $urandom(), pick_position(0));
        end
        default: begin
          phase_len     = $urandom_range(40, 160);
          insert_weight = $urandom_range(15, 85);
          repeat (phase_len) begin
            r = $urandom_range(0, 99);
            if (r < 3) send_request(REQ_NONE, $urandom(), POS_W'($urandom()));
            else if (r < insert_weight) begin
              send_request(REQ_INSERT, pick_value(), POS_W'($urandom()));
            end
            else send_request($urandom_range(0, 1) ? REQ_READ : REQ_DELETE,
                              $urandom(), pick_position(sb.fill));
          end
        end
      endcase
      if ($urandom_range(0, 2) == 0) drain_results();
    end

    drain_results();
    repeat (12) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[sorted_list_engine_top] OK");
    end else begin
      $display("[sorted_list_engine_top] ERROR");
    end
    $finish;
  end

endmodule
